// ===== src/mrrp_pkg.sv =====
package mrrp_pkg;

  // Configuration port geometry.
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;

  // Register indexes on the configuration port (paddr bit 2).
  typedef enum logic {
    REG_DEVICE_ADDRESS = 1'b0,
    REG_FUNCTION_CODE  = 1'b1
  } reg_idx_e;

  // Reset values of the configuration registers.
  localparam logic [7:0] DevAddrRst  = 8'h01;
  localparam logic [7:0] FuncCodeRst = 8'h04;

  // Result status codes.
  localparam logic [1:0] StatusOk     = 2'd0;
  localparam logic [1:0] StatusBadCrc = 2'd1;
  localparam logic [1:0] StatusNoResp = 2'd2;

  // CRC-16/MODBUS constants.
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  // Parser phases, one-hot.
  typedef enum logic [5:0] {
    PH_HUNT  = 6'b000001,
    PH_COUNT = 6'b000010,
    PH_DATA  = 6'b000100,
    PH_CRCLO = 6'b001000,
    PH_CRCHI = 6'b010000,
    PH_DONE  = 6'b100000
  } phase_e;

  // One classified byte as it travels from the front to the back.
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       last;
    logic       is_addr;
    logic       is_func;
  } item_t;

  // One finished result.
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] value_word;
    logic [7:0]  data_byte_count;
  } result_t;

  // Handshake between the front queue and the back parser.
  typedef struct packed {
    logic  valid;
    item_t item;
  } link_t;

  // Reflected CRC-16 update over one byte.
  function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== src/mrrp_front.sv =====
module mrrp_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  output logic                 full_o,
  input  logic [7:0]           rx_byte_i,
  input  logic                 end_of_reply_i,
  input  logic [7:0]           dev_addr_i,
  input  logic [7:0]           func_code_i,
  output mrrp_pkg::link_t      link_o,
  input  logic                 link_ready_i
);
  import mrrp_pkg::*;

  item_t      mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;
  item_t      cls;

  // Classify the incoming byte against the configured address and function.
  always_comb begin
    cls.rx_byte = rx_byte_i;
    cls.last    = end_of_reply_i;
    cls.is_addr = (rx_byte_i == dev_addr_i);
    cls.is_func = (rx_byte_i == func_code_i);
  end

  assign full_o      = cnt_q[1];
  assign do_push     = push_i && !full_o;
  assign link_o.valid = (cnt_q != 2'd0);
  assign link_o.item  = mem_q[rd_ptr_q];
  assign do_pop      = link_o.valid && link_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  // Queue pointers and occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cls;
    end
  end

endmodule

// ===== src/mrrp_back.sv =====
module mrrp_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mrrp_pkg::link_t  link_i,
  output logic             link_ready_o,
  output logic             empty_o,
  input  logic             pop_i,
  output logic [1:0]       status_o,
  output logic [31:0]      value_word_o,
  output logic [7:0]       data_byte_count_o
);
  import mrrp_pkg::*;

  phase_e      phase_q, phase_d;
  logic [15:0] prev_crc_q, prev_crc_d;
  logic        prev_addr_q, prev_addr_d;
  logic        prev_valid_q, prev_valid_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  rem_q, rem_d;
  logic [7:0]  count_q, count_d;
  logic [31:0] word_q, word_d;
  logic [2:0]  idx_q, idx_d;
  logic [7:0]  crc_lo_q, crc_lo_d;
  logic [1:0]  verdict_q, verdict_d;

  logic        consume;
  logic [7:0]  b;
  logic        rq_push, rq_pop;
  result_t     res;
  result_t     rq_mem_q [2];
  logic        rq_wr_q, rq_rd_q;
  logic [1:0]  rq_cnt_q, rq_cnt_d;

  assign link_ready_o = !rq_cnt_q[1];
  assign consume      = link_i.valid && link_ready_o;
  assign b            = link_i.item.rx_byte;

  // Frame parser: next state for one consumed byte.
  always_comb begin
    phase_d      = phase_q;
    prev_crc_d   = prev_crc_q;
    prev_addr_d  = prev_addr_q;
    prev_valid_d = prev_valid_q;
    crc_d        = crc_q;
    rem_d        = rem_q;
    count_d      = count_q;
    word_d       = word_q;
    idx_d        = idx_q;
    crc_lo_d     = crc_lo_q;
    verdict_d    = verdict_q;
    rq_push      = 1'b0;
    res          = '0;
    if (consume) begin
      unique case (phase_q)
        PH_HUNT: begin
          if (prev_valid_q && prev_addr_q && link_i.item.is_func) begin
            crc_d   = crc_feed(prev_crc_q, b);
            phase_d = PH_COUNT;
          end else begin
            // Keep the CRC of this byte ready in case it starts a frame.
            prev_crc_d   = crc_feed(CrcInit, b);
            prev_addr_d  = link_i.item.is_addr;
            prev_valid_d = 1'b1;
          end
        end
        PH_COUNT: begin
          crc_d   = crc_feed(crc_q, b);
          count_d = b;
          rem_d   = b;
          phase_d = (b == 8'd0) ? PH_CRCLO : PH_DATA;
        end
        PH_DATA: begin
          crc_d = crc_feed(crc_q, b);
          if (!idx_q[2]) begin
            unique case (idx_q[1:0])
              2'd0: word_d[31:24] = b;
              2'd1: word_d[23:16] = b;
              2'd2: word_d[15:8]  = b;
              2'd3: word_d[7:0]   = b;
              default: word_d = word_q;
            endcase
            idx_d = idx_q + 3'd1;
          end
          rem_d = rem_q - 8'd1;
          if (rem_q == 8'd1) begin
            phase_d = PH_CRCLO;
          end
        end
        PH_CRCLO: begin
          crc_lo_d = b;
          phase_d  = PH_CRCHI;
        end
        PH_CRCHI: begin
          verdict_d = ({b, crc_lo_q} == crc_q) ? StatusOk : StatusBadCrc;
          phase_d   = PH_DONE;
        end
        default: begin
          phase_d = phase_q;
        end
      endcase

      // The last byte of a reply emits the result and restarts the parse.
      if (link_i.item.last) begin
        rq_push             = 1'b1;
        res.status          = verdict_d;
        res.value_word      = (verdict_d == StatusOk) ? word_d : 32'd0;
        res.data_byte_count = count_d;
        phase_d      = PH_HUNT;
        prev_crc_d   = CrcInit;
        prev_addr_d  = 1'b0;
        prev_valid_d = 1'b0;
        crc_d        = CrcInit;
        rem_d        = 8'd0;
        count_d      = 8'd0;
        word_d       = 32'd0;
        idx_d        = 3'd0;
        crc_lo_d     = 8'd0;
        verdict_d    = StatusNoResp;
      end
    end
  end

  // Parser state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HUNT;
      prev_crc_q   <= CrcInit;
      prev_addr_q  <= 1'b0;
      prev_valid_q <= 1'b0;
      crc_q        <= CrcInit;
      rem_q        <= 8'd0;
      count_q      <= 8'd0;
      word_q       <= 32'd0;
      idx_q        <= 3'd0;
      crc_lo_q     <= 8'd0;
      verdict_q    <= StatusNoResp;
    end else begin
      phase_q      <= phase_d;
      prev_crc_q   <= prev_crc_d;
      prev_addr_q  <= prev_addr_d;
      prev_valid_q <= prev_valid_d;
      crc_q        <= crc_d;
      rem_q        <= rem_d;
      count_q      <= count_d;
      word_q       <= word_d;
      idx_q        <= idx_d;
      crc_lo_q     <= crc_lo_d;
      verdict_q    <= verdict_d;
    end
  end

  // Two-entry result queue toward the consumer.
  assign empty_o           = (rq_cnt_q == 2'd0);
  assign rq_pop            = pop_i && !empty_o;
  assign status_o          = rq_mem_q[rq_rd_q].status;
  assign value_word_o      = rq_mem_q[rq_rd_q].value_word;
  assign data_byte_count_o = rq_mem_q[rq_rd_q].data_byte_count;

  always_comb begin
    rq_cnt_d = rq_cnt_q;
    if (rq_push && !rq_pop) begin
      rq_cnt_d = rq_cnt_q + 2'd1;
    end else if (!rq_push && rq_pop) begin
      rq_cnt_d = rq_cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rq_wr_q  <= 1'b0;
      rq_rd_q  <= 1'b0;
      rq_cnt_q <= 2'd0;
    end else begin
      rq_cnt_q <= rq_cnt_d;
      if (rq_push) begin
        rq_wr_q <= ~rq_wr_q;
      end
      if (rq_pop) begin
        rq_rd_q <= ~rq_rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rq_push) begin
      rq_mem_q[rq_wr_q] <= res;
    end
  end

endmodule

// ===== src/modbus_rtu_reply_parser.sv =====
// Channel   Direction  Handshake                      Payload
// bytes     in         push_i / full_o                rx_byte_i, end_of_reply_i
// results   out        empty_o / pop_i                status_o, value_word_o,
//                                                     data_byte_count_o
// config    in         psel/penable/pwrite/pready     paddr, pwdata, prdata
//
// One byte is taken per cycle while full_o is low; the CRC update of one byte is the longest path.
// A byte passes the two-entry byte queue and the parser, and its result is
// registered in the two-entry result queue before it shows on the result
// ports, where it can be popped while empty_o is low.
// Reset puts the parser in the hunting phase and loads the register defaults.
// The parser stops only when both result entries are waiting; the byte queue
// then fills and raises full_o.
module modbus_rtu_reply_parser (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  output logic                           full_o,
  input  logic [7:0]                     rx_byte_i,
  input  logic                           end_of_reply_i,
  output logic                           empty_o,
  input  logic                           pop_i,
  output logic [1:0]                     status_o,
  output logic [31:0]                    value_word_o,
  output logic [7:0]                     data_byte_count_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mrrp_pkg::ApbAddrW-1:0]  paddr,
  input  logic [mrrp_pkg::ApbDataW-1:0]  pwdata,
  output logic [mrrp_pkg::ApbDataW-1:0]  prdata,
  output logic                           pready
);
  import mrrp_pkg::*;

  logic [7:0] dev_addr_q;
  logic [7:0] func_code_q;
  logic       cfg_wr;
  reg_idx_e   reg_sel;
  link_t      link;
  logic       link_ready;

  // Configuration registers.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q  <= DevAddrRst;
      func_code_q <= FuncCodeRst;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_DEVICE_ADDRESS: dev_addr_q  <= pwdata[7:0];
        REG_FUNCTION_CODE:  func_code_q <= pwdata[7:0];
        default: dev_addr_q <= dev_addr_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_DEVICE_ADDRESS: prdata = {{(ApbDataW-8){1'b0}}, dev_addr_q};
      REG_FUNCTION_CODE:  prdata = {{(ApbDataW-8){1'b0}}, func_code_q};
      default:            prdata = '0;
    endcase
  end

  // Byte classifier and queue.
  mrrp_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push_i),
    .full_o         (full_o),
    .rx_byte_i      (rx_byte_i),
    .end_of_reply_i (end_of_reply_i),
    .dev_addr_i     (dev_addr_q),
    .func_code_i    (func_code_q),
    .link_o         (link),
    .link_ready_i   (link_ready)
  );

  // Frame parser and result queue.
  mrrp_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .link_i            (link),
    .link_ready_o      (link_ready),
    .empty_o           (empty_o),
    .pop_i             (pop_i),
    .status_o          (status_o),
    .value_word_o      (value_word_o),
    .data_byte_count_o (data_byte_count_o)
  );

`ifndef SYNTHESIS
  // A waiting result never carries an unused status code.
  a_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> (status_o != 2'd3))
    else $error("result status out of range");

  // The value word is zero unless the frame checked out.
  a_value_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && (status_o != StatusOk)) |-> (value_word_o == 32'd0))
    else $error("value word set on a failed frame");

  // The byte queue fills only after a request was taken.
  a_full_after_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full_o) |-> $past(push_i))
    else $error("byte queue filled without a request");

  // A queued byte stays offered while the result queue is full and the parser stalls.
  a_back_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (link.valid && !link_ready) |=> link.valid)
    else $error("queued byte lost while the parser stalled");
`endif

endmodule
